// ===== sv/rgb_led_pattern_sequencer_macros.svh =====
// Assertion macros shared by the RGB LED pattern sequencer RTL.
`ifndef RGB_LED_PATTERN_SEQUENCER_MACROS_SVH
`define RGB_LED_PATTERN_SEQUENCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLPS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/rlps_pkg.sv =====
// Types, constants and helper functions of the RGB LED pattern sequencer.
package rlps_pkg;

   localparam int PHASE_PERIOD = 1024;
   localparam int TIME_WIDTH   = 16;

   localparam int PHASE_W  = $clog2(PHASE_PERIOD);
   localparam int PULSE_W  = (PHASE_W + 5 > 15) ? PHASE_W + 5 : 15;
   localparam int CMP_W    = 15;
   localparam int LEVEL_W  = 8;
   localparam int KIND_W   = 2;
   localparam int TIME_IN_W = 16;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;

   localparam logic [CMP_W-1:0] DARK = 15'h4000;

   // Largest count the time registers hold, as a 64-bit value.
   localparam logic [63:0] TIME_MAX = (64'd1 << TIME_WIDTH) - 64'd1;

   typedef enum logic [1:0] {
      CMD_TICK        = 2'd0,
      CMD_SET_BASE    = 2'd1,
      CMD_SET_DELAYED = 2'd2,
      CMD_OVERRIDE    = 2'd3
   } command_type;

   localparam logic [KIND_W-1:0] KIND_SOLID = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BLINK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PULSE = 2'd2;
   // The fourth kind code has no meaning of its own and is shown as pulse.
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } pattern_type;

   // 16384 - (16384 * c) / 255. Since 16384 = 64 * 255 + 64, the quotient
   // is 64 * c + (64 * c) / 255, and the second term is taken as (y >> 8)
   // plus one correction step.
   function automatic logic [CMP_W-1:0] level_compare(input logic [LEVEL_W-1:0] c);
      logic [13:0] y;
      logic [5:0]  q0;
      logic [8:0]  r;
      logic [6:0]  q;
      y  = {c, 6'b0};
      q0 = y[13:8];
      r  = 9'(y[7:0]) + 9'(q0);
      q  = 7'(q0) + 7'(r >= 9'd255);
      return DARK - 15'({c, 6'b0}) - 15'(q);
   endfunction

endpackage

// ===== sv/rgb_led_pattern_sequencer.sv =====
// RGB LED pattern sequencer: command decode, pattern state and PWM compare output.
//
//   Channel  Direction  Carries
//   req_     in         one command: tuser = command, tdata = pattern and time
//   rsp_     out        one result per command: compares, base pattern, flag
//
// Every accepted command produces exactly one result transfer, offered from the result register in the next cycle.
// A new command is taken in every cycle while the result register is empty or
// being drained, so the sustained rate is one command per clock.
// The whole step (delay countdown, pattern choice, compare math, phase update)
// is one pass of combinational logic from the state registers to the result.
// Reset is synchronous and active high; it sets the base pattern to dark solid,
// clears the counters and drops rsp_tvalid.
// When rsp_tready is low while a result is waiting, the result holds and req_tready drops with it.

`include "rgb_led_pattern_sequencer_macros.svh"

module rgb_led_pattern_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] kind, [9:2] red_level, [17:10] green_level, [25:18] blue_level,
   // [41:26] time_ms, [47:42] zero
   input  logic [rlps_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] command
   input  logic [rlps_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [14:0] red_compare, [29:15] green_compare, [44:30] blue_compare,
   // [46:45] base_kind, [54:47] base_red, [62:55] base_green,
   // [70:63] base_blue, [71] override_active
   output logic [rlps_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import rlps_pkg::*;

   // State registers.
   pattern_type               base_ff, base_in;
   pattern_type               delayed_ff, delayed_in;
   pattern_type               override_pat_ff, override_pat_in;
   logic [TIME_WIDTH-1:0]     delay_left_ff, delay_left_in;
   logic [TIME_WIDTH-1:0]     override_left_ff, override_left_in;
   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic [CMP_W-1:0]          compare_ff [3];
   logic [CMP_W-1:0]          compare_in [3];

   // Result register.
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   // Decoded request.
   logic                      req_accept;
   command_type               cmd;
   pattern_type               item;
   logic [TIME_IN_W-1:0]      time_raw;
   logic [TIME_WIDTH-1:0]     time_sat;
   logic                      base_write;
   logic                      pattern_write;
   logic                      override_busy;

   // Tick path.
   logic [TIME_WIDTH-1:0]     delay_mid;
   pattern_type               base_mid;
   logic [PHASE_W-1:0]        phase_mid;
   pattern_type               shown;
   logic                      blink_on;
   logic [LEVEL_W-1:0]        lvl_r, lvl_g, lvl_b;
   logic [PHASE_W-1:0]        tri_val;
   logic [PULSE_W-1:0]        pulse_s;
   logic [CMP_W-1:0]          pulse_v;
   logic [CMP_W-1:0]          tick_cmp [3];
   logic [PHASE_W-1:0]        phase_shown;
   logic [PHASE_W-1:0]        phase_next;

   // The result register is free when empty or being taken this cycle.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign cmd        = command_type'(req_tuser);
   assign item.kind  = req_tdata[1:0];
   assign item.red   = req_tdata[9:2];
   assign item.green = req_tdata[17:10];
   assign item.blue  = req_tdata[25:18];
   assign time_raw   = req_tdata[41:26];

   // Accepted writes of a base pattern, and of a delayed or override pattern.
   assign base_write    = req_accept && cmd == CMD_SET_BASE;
   assign pattern_write = req_accept && (cmd == CMD_SET_DELAYED || cmd == CMD_OVERRIDE);
   assign override_busy = override_left_ff != '0;

   // Times beyond what the counters hold saturate at their maximum.
   assign time_sat = (64'(time_raw) > TIME_MAX) ? TIME_WIDTH'(TIME_MAX)
                                                : TIME_WIDTH'(time_raw);

   // Tick, part one: a pending delayed pattern counts down and, on reaching
   // zero, is applied like a base write (the phase clears only if it differs).
   always_comb begin
      delay_mid = delay_left_ff;
      base_mid  = base_ff;
      phase_mid = phase_ff;
      if (delay_left_ff != '0) begin
         delay_mid = delay_left_ff - TIME_WIDTH'(1);
         if (delay_mid == '0) begin
            if (base_ff != delayed_ff) begin
               phase_mid = '0;
            end
            base_mid = delayed_ff;
         end
      end
   end

   // Tick, part two: the override pattern wins while its time remains.
   assign shown = override_busy ? override_pat_ff : base_mid;

   // Blink shows the levels only in the first 64 phase steps.
   assign blink_on = phase_mid < PHASE_W'(64);
   always_comb begin
      lvl_r = shown.red;
      lvl_g = shown.green;
      lvl_b = shown.blue;
      if (shown.kind == KIND_BLINK && !blink_on) begin
         lvl_r = '0;
         lvl_g = '0;
         lvl_b = '0;
      end
   end

   // Pulse is a triangle over the phase period, clamped at full brightness.
   assign tri_val = (phase_mid < PHASE_W'(PHASE_PERIOD / 2)) ?
                    phase_mid : PHASE_W'(PHASE_PERIOD) - phase_mid;
   assign pulse_s = PULSE_W'(tri_val) << 5;
   assign pulse_v = (pulse_s >= PULSE_W'(DARK)) ? '0
                                                : CMP_W'(PULSE_W'(DARK) - pulse_s);

   always_comb begin
      phase_shown = phase_mid;
      case (shown.kind)
         KIND_SOLID, KIND_BLINK: begin
            tick_cmp[0] = level_compare(lvl_r);
            tick_cmp[1] = level_compare(lvl_g);
            tick_cmp[2] = level_compare(lvl_b);
            if (shown.kind == KIND_BLINK) begin
               phase_shown = phase_mid & PHASE_W'(8'hFF);
            end
         end
         default: begin
            // Pulse, and the unused kind code, which is shown as pulse.
            tick_cmp[0] = (shown.red   != '0) ? pulse_v : DARK;
            tick_cmp[1] = (shown.green != '0) ? pulse_v : DARK;
            tick_cmp[2] = (shown.blue  != '0) ? pulse_v : DARK;
         end
      endcase
   end

   assign phase_next = (phase_shown == PHASE_W'(PHASE_PERIOD - 1)) ? '0
                                                                    : phase_shown + PHASE_W'(1);

   // Next state for the accepted command.
   always_comb begin
      base_in          = base_ff;
      delayed_in       = delayed_ff;
      override_pat_in  = override_pat_ff;
      delay_left_in    = delay_left_ff;
      override_left_in = override_left_ff;
      phase_in         = phase_ff;
      compare_in       = compare_ff;
      if (req_accept) begin
         case (cmd)
            CMD_SET_BASE: begin
               if (base_ff != item) begin
                  phase_in = '0;
               end
               base_in       = item;
               delay_left_in = '0;
            end
            CMD_SET_DELAYED: begin
               delayed_in    = item;
               delay_left_in = time_sat;
            end
            CMD_OVERRIDE: begin
               override_pat_in  = item;
               override_left_in = time_sat;
            end
            default: begin
               base_in       = base_mid;
               delay_left_in = delay_mid;
               if (override_busy) begin
                  override_left_in = override_left_ff - TIME_WIDTH'(1);
               end
               compare_in = tick_cmp;
               phase_in   = phase_next;
            end
         endcase
      end
   end

   // The result reports the state as it stands after the command.
   assign rsp_tdata_in = {override_left_in != '0, base_in.blue, base_in.green,
                          base_in.red, base_in.kind,
                          compare_in[2], compare_in[1], compare_in[0]};
   assign rsp_tvalid_in = req_accept || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff          <= '0;
         delay_left_ff    <= '0;
         override_left_ff <= '0;
         phase_ff         <= '0;
         compare_ff[0]    <= DARK;
         compare_ff[1]    <= DARK;
         compare_ff[2]    <= DARK;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         base_ff          <= base_in;
         delay_left_ff    <= delay_left_in;
         override_left_ff <= override_left_in;
         phase_ff         <= phase_in;
         compare_ff       <= compare_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
      end
   end

   // Payload registers; the stored patterns are read only after being written.
   always_ff @(posedge clock) begin
      delayed_ff      <= delayed_in;
      override_pat_ff <= override_pat_in;
      if (req_accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   // Every accepted command leaves a result waiting in the next cycle.
   `RLPS_ASSERT_NEXT(a_result_follows, req_accept, rsp_tvalid_ff, "command gave no result")
   // Delayed and override writes never move the phase.
   `RLPS_ASSERT_NEXT(a_phase_kept, pattern_write, $stable(phase_ff), "phase moved on a write")
   // A base write cancels any pending delayed pattern.
   `RLPS_ASSERT_NEXT(a_delay_cancel, base_write, delay_left_ff == '0, "delay left pending")
   // The reported override flag matches the override counter while shown.
   `RLPS_ASSERT_SAME(a_flag_match, rsp_tvalid_ff, rsp_tdata_ff[71] == override_busy, "bad flag")

endmodule

// ===== sim/rgb_led_pattern_sequencer_tb.sv =====
// Self-checking testbench for the RGB LED pattern sequencer command and status streams.
module rgb_led_pattern_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rlps_pkg::*;

   // The run is cut off after this many nanoseconds. A correct run ends well
   // before that even with every gap and stall at its longest.
   localparam int unsigned RUN_LIMIT_NS   = 2_000_000;
   localparam int unsigned ITEM_TARGET    = 1000;
   localparam int unsigned LEVEL_FULL     = 255;
   localparam int unsigned BLINK_LIT_SPAN = 64;
   localparam int unsigned BLINK_WRAP     = 8'hFF;
   localparam int unsigned MAX_SHOWN      = 10;
   localparam int unsigned HOLD_OFF_AFTER = 300;
   localparam int unsigned HOLD_OFF_SPAN  = 400;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int          PATTERN_W      = $bits(pattern_type);

   // One command as the generator queues it.
   typedef struct {
      command_type      cmd;
      pattern_type      pat;
      logic [15:0]      duration;
   } led_command_type;

   // One status transfer, laid out exactly as rsp_tdata from the top bit down.
   typedef struct packed {
      logic             override_on;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic [1:0]       kind;
      logic [14:0]      blue_cmp;
      logic [14:0]      green_cmp;
      logic [14:0]      red_cmp;
   } led_status_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   rgb_led_pattern_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Commands waiting to be driven, and status words the block still owes us.
   led_command_type  pending_cmds[$];
   led_status_type   expected_status[$];
   int unsigned      total_cmds;

   // Flags raised at the rising edge when a transfer happened on a channel,
   // consumed by the driving processes at the following falling edge.
   bit            cmd_taken;
   bit            status_taken;
   bit            hold_off;

   int unsigned   cmds_accepted;
   int unsigned   status_checked;
   int unsigned   mismatch_count;
   int unsigned   tick_count;
   int unsigned   base_sets;
   int unsigned   delayed_sets;
   int unsigned   override_sets;
   int unsigned   deepest_phase;

   // ------------------------------------------------------------------
   // Behavioral model of the sequencer. It mirrors the block's state and
   // produces one status word for every command the block accepts.
   // ------------------------------------------------------------------
   pattern_type   base_pat;
   pattern_type   queued_pat;
   pattern_type   override_pat;
   int unsigned   delay_left;
   int unsigned   override_left;
   int unsigned   phase;
   logic [14:0]   held_cmp[3];

   function automatic logic [14:0] level_to_compare(input logic [7:0] level);
      int unsigned scaled;
      scaled = (32'(DARK) * 32'(level)) / LEVEL_FULL;
      return 15'(32'(DARK) - scaled);
   endfunction

   // A new base pattern restarts the animation only when it actually
   // differs; either way any pending delayed pattern is dropped.
   function automatic void adopt_base(input pattern_type p);
      if (p != base_pat)
         phase = 0;
      base_pat   = p;
      delay_left = 0;
   endfunction

   function automatic void render_pattern(input pattern_type p);
      int unsigned ramp;
      int unsigned slope;
      int unsigned pulse_cmp;
      logic        lit;
      case (p.kind)
         KIND_SOLID: begin
            held_cmp[0] = level_to_compare(p.red);
            held_cmp[1] = level_to_compare(p.green);
            held_cmp[2] = level_to_compare(p.blue);
         end
         KIND_BLINK: begin
            lit         = phase < BLINK_LIT_SPAN;
            held_cmp[0] = level_to_compare(lit ? p.red : 8'd0);
            held_cmp[1] = level_to_compare(lit ? p.green : 8'd0);
            held_cmp[2] = level_to_compare(lit ? p.blue : 8'd0);
            phase       = phase & BLINK_WRAP;
         end
         default: begin
            // Pulse, and the spare fourth kind, which is shown the same way.
            ramp        = (phase < PHASE_PERIOD / 2) ? phase : PHASE_PERIOD - phase;
            slope       = ramp << 5;
            pulse_cmp   = (slope >= DARK) ? 0 : DARK - slope;
            held_cmp[0] = (p.red != 0)   ? 15'(pulse_cmp) : DARK;
            held_cmp[1] = (p.green != 0) ? 15'(pulse_cmp) : DARK;
            held_cmp[2] = (p.blue != 0)  ? 15'(pulse_cmp) : DARK;
         end
      endcase
   endfunction

   function automatic led_status_type advance_sequencer(input led_command_type c);
      led_status_type s;
      case (c.cmd)
         CMD_SET_BASE: begin
            adopt_base(c.pat);
            base_sets++;
         end
         CMD_SET_DELAYED: begin
            queued_pat = c.pat;
            delay_left = c.duration;
            delayed_sets++;
         end
         CMD_OVERRIDE: begin
            override_pat  = c.pat;
            override_left = c.duration;
            override_sets++;
         end
         default: begin
            // A tick.
            if (delay_left > 0) begin
               delay_left--;
               if (delay_left == 0)
                  adopt_base(queued_pat);
            end
            if (override_left > 0) begin
               override_left--;
               render_pattern(override_pat);
            end else begin
               render_pattern(base_pat);
            end
            if (phase > deepest_phase)
               deepest_phase = phase;
            phase = (phase + 1) % PHASE_PERIOD;
            tick_count++;
         end
      endcase
      s.red_cmp     = held_cmp[0];
      s.green_cmp   = held_cmp[1];
      s.blue_cmp    = held_cmp[2];
      s.kind        = base_pat.kind;
      s.red         = base_pat.red;
      s.green       = base_pat.green;
      s.blue        = base_pat.blue;
      s.override_on = override_left != 0;
      return s;
   endfunction

   // ------------------------------------------------------------------
   // Command generation.
   // ------------------------------------------------------------------
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pattern_type pick_pattern();
      pattern_type p;
      p.kind  = 2'($urandom_range(0, 3));
      p.red   = pick_level();
      p.green = pick_level();
      p.blue  = pick_level();
      return p;
   endfunction

   // Delays and override lengths are mostly short so that they run out while
   // we watch; now and then they sit at the ends of the range.
   function automatic logic [15:0] pick_duration();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(1, 40));
      endcase
   endfunction

   function automatic void queue_command(input command_type cmd, input pattern_type p,
                                         input logic [15:0] duration);
      led_command_type c;
      c.cmd      = cmd;
      c.pat      = p;
      c.duration = duration;
      pending_cmds.push_back(c);
   endfunction

   // Ticks ignore their payload, so it is filled with noise.
   function automatic void queue_ticks(input int unsigned count);
      repeat (count)
         queue_command(CMD_TICK, pattern_type'(PATTERN_W'($urandom())), 16'($urandom()));
   endfunction

   function automatic pattern_type make_pattern(input logic [1:0] kind, input logic [7:0] r,
                                                input logic [7:0] g, input logic [7:0] b);
      pattern_type p;
      p.kind  = kind;
      p.red   = r;
      p.green = g;
      p.blue  = b;
      return p;
   endfunction

   initial begin
      pattern_type solid_mix;
      pattern_type blink_mix;
      pattern_type pulse_dim;
      pattern_type last_base;
      pattern_type p;
      int unsigned directed_count;
      bit          long_run_done;

      solid_mix = make_pattern(KIND_SOLID, 8'd255, 8'd0, 8'd128);
      blink_mix = make_pattern(KIND_BLINK, 8'd0, 8'd255, 8'd1);
      pulse_dim = make_pattern(KIND_PULSE, 8'd1, 8'd1, 8'd0);

      // Directed opening: reset state, every command, both ends of each field,
      // and the corner behaviors of pattern updates.
      queue_ticks(1);                                        // dark after reset
      queue_command(CMD_SET_BASE, solid_mix, 16'd0);
      queue_ticks(1);
      queue_command(CMD_SET_BASE, solid_mix, 16'hFFFF);      // equal pattern keeps phase
      queue_ticks(1);
      queue_command(CMD_SET_BASE, blink_mix, 16'd0);
      queue_ticks(2);
      queue_command(CMD_OVERRIDE, make_pattern(KIND_SPARE, 8'd255, 8'd0, 8'd7), 16'd3);
      queue_ticks(2);                                        // fourth kind shows as pulse
      queue_command(CMD_OVERRIDE, solid_mix, 16'd0);         // zero length ends override
      queue_ticks(1);
      queue_command(CMD_SET_DELAYED, pulse_dim, 16'd2);
      queue_ticks(2);                                        // delayed pattern lands
      queue_command(CMD_SET_DELAYED, pulse_dim, 16'd1);      // lands equal, phase kept
      queue_ticks(1);
      queue_command(CMD_SET_DELAYED, solid_mix, 16'd0);      // zero delay leaves nothing
      queue_command(CMD_SET_DELAYED, blink_mix, 16'hFFFF);
      queue_command(CMD_SET_BASE, make_pattern(KIND_SOLID, 8'd0, 8'd0, 8'd0), 16'd0);
      queue_ticks(1);                                        // pending delay was cancelled
      queue_command(CMD_OVERRIDE, make_pattern(KIND_SOLID, 8'd255, 8'd255, 8'd255),
                    16'hFFFF);
      queue_ticks(1);
      queue_command(CMD_OVERRIDE, blink_mix, 16'd0);
      directed_count = pending_cmds.size();
      last_base      = make_pattern(KIND_SOLID, 8'd0, 8'd0, 8'd0);
      long_run_done  = 1'b0;

      // Random part: well-formed segments, a pattern update followed by a run
      // of ticks, with some raw noise mixed in.
      while (pending_cmds.size() < ITEM_TARGET) begin
         if (!long_run_done && pending_cmds.size() > directed_count + ITEM_TARGET / 3) begin
            // One pulse run long enough to cross the top of the triangle.
            last_base = make_pattern(KIND_PULSE, 8'd200, 8'd0, 8'd9);
            queue_command(CMD_OVERRIDE, pick_pattern(), 16'd0);
            queue_command(CMD_SET_BASE, last_base, 16'd0);
            queue_ticks(560);
            long_run_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               p = ($urandom_range(0, 3) == 0) ? last_base : pick_pattern();
               last_base = p;
               queue_command(CMD_SET_BASE, p, 16'($urandom()));
            end
            4, 5: begin
               p = ($urandom_range(0, 3) == 0) ? last_base : pick_pattern();
               queue_command(CMD_SET_DELAYED, p, pick_duration());
            end
            6, 7: queue_command(CMD_OVERRIDE, pick_pattern(), pick_duration());
            8: begin
               repeat ($urandom_range(1, 4))
                  queue_command(command_type'($urandom_range(0, 3)),
                                pattern_type'(PATTERN_W'($urandom())), 16'($urandom()));
            end
            default: queue_ticks($urandom_range(60, 250));
         endcase
         queue_ticks($urandom_range(1, 40));
      end
      total_cmds = pending_cmds.size();
   end

   // ------------------------------------------------------------------
   // Command driver: presents queued commands at the falling edge and waits a
   // random number of cycles after each transfer. Every 64 commands it may
   // switch into a stretch with no idling at all.
   // ------------------------------------------------------------------
   int unsigned   send_gap;
   int unsigned   sent_count;
   bit            send_calm;

   always @(negedge clock) begin
      led_command_type c;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || cmd_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            c = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= c.cmd;
            req_tdata  <= {6'b0, c.duration, c.pat.blue, c.pat.green, c.pat.red, c.pat.kind};
            if (sent_count % 64 == 0)
               send_calm = ($urandom_range(0, 2) == 0);
            sent_count++;
            send_gap = send_calm ? 0 : $urandom_range(0, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      cmd_taken = 1'b0;
   end

   // ------------------------------------------------------------------
   // Status receiver: stalls a random number of cycles after each transfer,
   // and holds off entirely while the long back-pressure window is open.
   // ------------------------------------------------------------------
   int unsigned   recv_stall;
   bit            recv_calm;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (status_taken) begin
            if (status_checked % 64 == 0)
               recv_calm = ($urandom_range(0, 2) == 0);
            recv_stall = recv_calm ? 0 : $urandom_range(0, 6);
         end
         if (hold_off) begin
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
      status_taken = 1'b0;
   end

   // Once a few hundred commands are through, the receiver stops taking status
   // words for a long window. The driver keeps offering commands, so the
   // block fills its output register and has to stall its command input.
   initial begin
      while (cmds_accepted < HOLD_OFF_AFTER)
         @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_OFF_SPAN) @(posedge clock);
      hold_off = 1'b0;
   end

   // ------------------------------------------------------------------
   // Monitor: at each rising edge, feeds accepted commands to the model and
   // checks each accepted status word against the oldest expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      led_command_type c;
      led_status_type  got;
      led_status_type  want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            c.cmd      = command_type'(req_tuser);
            c.pat.kind  = req_tdata[1:0];
            c.pat.red   = req_tdata[9:2];
            c.pat.green = req_tdata[17:10];
            c.pat.blue  = req_tdata[25:18];
            c.duration  = req_tdata[41:26];
            expected_status.push_back(advance_sequencer(c));
            cmds_accepted++;
            cmd_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = led_status_type'(rsp_tdata);
            status_taken = 1'b1;
            if (expected_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("[%0t] status transfer with nothing expected: %h", $realtime,
                           rsp_tdata);
            end else begin
               want = expected_status.pop_front();
               status_checked++;
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_SHOWN) begin
                     $display("[%0t] status %0d mismatch", $realtime, status_checked);
                     $display("   expected cmp %0d/%0d/%0d base %0d:%0d,%0d,%0d ovr %0b",
                              want.red_cmp, want.green_cmp, want.blue_cmp, want.kind,
                              want.red, want.green, want.blue, want.override_on);
                     $display("   got      cmp %0d/%0d/%0d base %0d:%0d,%0d,%0d ovr %0b",
                              got.red_cmp, got.green_cmp, got.blue_cmp, got.kind,
                              got.red, got.green, got.blue, got.override_on);
                  end
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Run control.
   // ------------------------------------------------------------------
   initial begin
      base_pat      = '0;
      queued_pat    = '0;
      override_pat  = '0;
      delay_left    = 0;
      override_left = 0;
      phase         = 0;
      held_cmp[0]   = DARK;
      held_cmp[1]   = DARK;
      held_cmp[2]   = DARK;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every command to go in and every status word to come back,
      // then keep running through the drain period so the block can show anything
      // it should not produce.
      while (total_cmds == 0 || cmds_accepted < total_cmds || expected_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d commands: %0d ticks, %0d base sets, %0d delayed sets, %0d overrides.",
               cmds_accepted, tick_count, base_sets, delayed_sets, override_sets);
      $display("Compared %0d status transfers; deepest phase %0d; %0d mismatches.",
               status_checked, deepest_phase, mismatch_count);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Timed out with %0d of %0d commands accepted, %0d status words owed.",
               cmds_accepted, total_cmds, expected_status.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rlps_pkg.sv
sv/rgb_led_pattern_sequencer.sv
sim/rgb_led_pattern_sequencer_tb.sv
